FILE: hw/rtl/olst_pkg.sv
`default_nettype none

package olst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 3;
    localparam int INDEX_W      = 5;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_DUMP   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_NEG   = 3'd2,
        ST_OOB   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ordered_list_store.sv
`default_nettype none

// Channel   Handshake              Payload
// request   req_valid/req_ready    func, value, position
// response  rsp_valid/rsp_ready    status, element, index, last
//
// Append and every rejected request complete in the idle state. Remove fetches the
// head, then shifts each later element down; insert shifts the elements from
// position up and writes the new value into the gap: each moved element is one
// read and one write on the element memory. Dump sends the elements in index order.
// Reset clears the element count, sequencer state and response valid; memory contents come up undefined.
// A stalled response holds the sequencer; req_ready is low until it is back in idle.
module ordered_list_store
    import olst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        req_valid,
    output logic                       req_ready,
    input  wire  [1:0]                 func,
    input  wire  signed [DATA_W-1:0]   value,
    input  wire  signed [POS_W-1:0]    position,
    output logic                       rsp_valid,
    input  wire                        rsp_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   element,
    output logic [INDEX_W-1:0]         index,
    output logic                       last
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_HEAD    = 8'b0000_0010,
        S_SH_RD   = 8'b0000_0100,
        S_SH_WR   = 8'b0000_1000,
        S_RESP    = 8'b0001_0000,
        S_DMP_RD  = 8'b0010_0000,
        S_DMP_OUT = 8'b0100_0000,
        S_SPARE   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  up_reg, up_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [DATA_W-1:0]     head_reg, head_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    status_t               status_reg, status_next;
    logic [DATA_W-1:0]     element_reg, element_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic                  last_reg, last_next;

    logic [DATA_W-1:0]     mem [CAPACITY];
    logic [DATA_W-1:0]     rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_W-1:0]     wr_data;

    logic [CW-1:0]         ptr_dec;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         src_ptr;
    logic                  rsp_free;
    logic                  full;
    logic                  empty;
    logic                  pos_neg;
    logic                  pos_oob;
    logic                  shift_more;
    logic                  accept;

    assign ptr_dec  = ptr_reg - CW'(1);
    assign ptr_inc  = ptr_reg + CW'(1);
    assign src_ptr  = up_reg ? ptr_dec : ptr_reg;
    // idle always fetches the head so a remove has it in the following cycle
    assign rd_addr  = (state_reg == S_IDLE) ? '0 : src_ptr[AW-1:0];

    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_neg  = position[POS_W-1];
    assign pos_oob  = CMPW'(position[POS_W-2:0]) > CMPW'(count_reg);
    assign shift_more = up_reg ? (ptr_reg > pos_reg) : (ptr_reg < count_reg);

    assign req_ready = (state_reg == S_IDLE) && rsp_free;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        up_next        = up_reg;
        value_next     = value_reg;
        head_next      = head_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        element_next   = element_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = value;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // default response: one-shot status with last set
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    element_next   = '0;
                    index_next     = '0;
                    last_next      = 1'b1;
                    case (func_t'(func))
                        FUNC_APPEND: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rsp_valid_next = 1'b0;
                                up_next        = 1'b0;
                                ptr_next       = CW'(1);
                                state_next     = S_HEAD;
                            end
                        end
                        FUNC_INSERT: begin
                            if (pos_neg) begin
                                status_next = ST_NEG;
                            end else if (pos_oob) begin
                                status_next = ST_OOB;
                                index_next  = INDEX_W'(count_reg);
                            end else if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                rsp_valid_next = 1'b0;
                                up_next        = 1'b1;
                                ptr_next       = count_reg;
                                pos_next       = CW'(position[POS_W-2:0]);
                                value_next     = value;
                                head_next      = '0;
                                state_next     = S_SH_RD;
                            end
                        end
                        default: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rsp_valid_next = 1'b0;
                                up_next        = 1'b0;
                                ptr_next       = '0;
                                state_next     = S_DMP_RD;
                            end
                        end
                    endcase
                end
            end
            S_HEAD: begin
                head_next  = rd_data_reg;
                state_next = S_SH_RD;
            end
            S_SH_RD: begin
                if (shift_more) begin
                    state_next = S_SH_WR;
                end else if (up_reg) begin
                    // gap is open: drop the new value in
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end
            S_SH_WR: begin
                wr_en      = 1'b1;
                wr_addr    = up_reg ? ptr_reg[AW-1:0] : ptr_dec[AW-1:0];
                wr_data    = rd_data_reg;
                ptr_next   = up_reg ? ptr_dec : ptr_inc;
                state_next = S_SH_RD;
            end
            S_RESP: begin
                if (rsp_free) begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    element_next   = head_reg;
                    index_next     = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DMP_RD: begin
                state_next = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                if (rsp_free) begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    element_next   = rd_data_reg;
                    index_next     = INDEX_W'(ptr_reg);
                    last_next      = (ptr_inc == count_reg);
                    if (ptr_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_inc;
                        state_next = S_DMP_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            up_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            up_reg        <= up_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        head_reg    <= head_next;
        status_reg  <= status_next;
        element_reg <= element_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign index     = index_reg;
    assign last      = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_APPEND && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the list");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |->
        (up_reg ? (ptr_reg > pos_reg && ptr_reg <= count_reg)
                : (ptr_reg < count_reg && ptr_reg != '0)))
        else $error("shift pointer out of range");

    a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_RD || state_reg == S_SH_WR) |=> !$past(accept))
        else $error("request taken during a shift");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
    import olst_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int RAND_ITEMS = 250;
    localparam int CYCLE_CAP  = 500000;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic [INDEX_W-1:0]       index;
        logic                     last;
    } list_result_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    func_t                      func      = FUNC_APPEND;
    logic signed [DATA_W-1:0]   value     = '0;
    logic signed [POS_W-1:0]    position  = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   element;
    logic [INDEX_W-1:0]         index;
    logic                       last;

    // Shadow of the list contents and the results still owed by the block
    logic signed [DATA_W-1:0]   list_vals [CAP];
    int                         list_len    = 0;
    list_result_t               expected_q[$];

    int                         fail_count  = 0;
    int                         rsp_wait    = 0;
    bit                         no_gaps     = 1'b0;
    int unsigned                cycle_count = 0;

    ordered_list_store #(
        .CAPACITY (CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .func      (func),
        .value     (value),
        .position  (position),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .element   (element),
        .index     (index),
        .last      (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("** ordered_list_store: FAILED **");
            $finish;
        end
    end

    function automatic void push_result(status_t s, logic signed [DATA_W-1:0] e,
                                        int i, logic l);
        list_result_t r;
        r.status  = s;
        r.element = e;
        r.index   = i[INDEX_W-1:0];
        r.last    = l;
        expected_q.push_back(r);
    endfunction

    function automatic void apply_list_op(func_t f, logic signed [DATA_W-1:0] v,
                                          logic signed [POS_W-1:0] p);
        logic signed [DATA_W-1:0] head;
        int                       slot;
        slot = int'(p);
        case (f)
            FUNC_APPEND:
            begin
                if (list_len >= CAP)
                    push_result(ST_FULL, '0, 0, 1'b1);
                else
                begin
                    list_vals[list_len] = v;
                    list_len++;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            FUNC_REMOVE:
            begin
                if (list_len == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                else
                begin
                    head = list_vals[0];
                    for (int k = 1; k < list_len; k++)
                        list_vals[k-1] = list_vals[k];
                    list_len--;
                    push_result(ST_OK, head, 0, 1'b1);
                end
            end
            FUNC_INSERT:
            begin
                // negative position wins over range, range wins over full
                if (slot < 0)
                    push_result(ST_NEG, '0, 0, 1'b1);
                else if (slot > list_len)
                    push_result(ST_OOB, '0, list_len, 1'b1);
                else if (list_len >= CAP)
                    push_result(ST_FULL, '0, 0, 1'b1);
                else
                begin
                    for (int k = list_len; k > slot; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[slot] = v;
                    list_len++;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            default:
            begin
                if (list_len == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int k = 0; k < list_len; k++)
                        push_result(ST_OK, list_vals[k], k, k == list_len - 1);
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(func_t f, logic signed [DATA_W-1:0] v,
                                logic signed [POS_W-1:0] p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        value     <= v;
        position  <= p;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_list_op(f, v, p);
    endtask

    always @(posedge clk)
    begin : rsp_check
        list_result_t exp_r;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response with no request pending: status %0d element %0d",
                           status, element);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, status);
                        fail_count++;
                    end
                    if (element !== exp_r.element)
                    begin
                        $error("element: expected %0d, got %0d", exp_r.element, element);
                        fail_count++;
                    end
                    if (index !== exp_r.index)
                    begin
                        $error("index: expected %0d, got %0d", exp_r.index, index);
                        fail_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_r.last, last);
                        fail_count++;
                    end
                end
                rsp_wait = no_gaps ? 0 : $urandom_range(0, 11);
            end
            if (rsp_wait > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_wait--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic test_empty_list();
        send_request(FUNC_REMOVE, 32'sh12345678, '0);
        send_request(FUNC_DUMP, '0, '0);
        send_request(FUNC_INSERT, 32'sd1, -6'sd1);
        send_request(FUNC_INSERT, 32'sd2, 6'sh20);
        send_request(FUNC_INSERT, 32'sd3, 6'sd1);
    endtask

    task automatic test_value_extremes();
        send_request(FUNC_INSERT, 32'sh80000000, 6'sd0);
        send_request(FUNC_APPEND, 32'sh7fffffff, 6'sh2a);
        send_request(FUNC_INSERT, -32'sd1, 6'sd1);
        // position equal to the count lands at the tail
        send_request(FUNC_INSERT, 32'sd0, 6'sd3);
        send_request(FUNC_INSERT, 32'sh5a5a5a5a, 6'sh1f);
        send_request(FUNC_DUMP, 32'sh0f0f0f0f, 6'sh15);
        send_request(FUNC_REMOVE, '0, '0);
        send_request(FUNC_REMOVE, '1, '1);
    endtask

    task automatic test_full_store();
        while (list_len < CAP)
            send_request(FUNC_APPEND, draw_value(), POS_W'($urandom()));
        send_request(FUNC_APPEND, 32'sd77, '0);
        send_request(FUNC_INSERT, 32'sd78, 6'sd16);
        send_request(FUNC_INSERT, 32'sd79, 6'sd17);
        send_request(FUNC_INSERT, 32'sd80, 6'sd0);
        send_request(FUNC_DUMP, '0, '0);
        send_request(FUNC_REMOVE, '0, '0);
        send_request(FUNC_INSERT, 32'sh80000001, 6'sd0);
    endtask

    task automatic test_random_traffic();
        func_t                   f;
        logic signed [POS_W-1:0] p;
        int                      pick;
        bit                      grow;
        grow = 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // change pacing and list direction every few dozen requests
            if (n % 35 == 0)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                grow    = ($urandom_range(0, 1) == 1);
            end
            pick = $urandom_range(0, 99);
            if (grow)
                f = (pick < 35) ? FUNC_APPEND : (pick < 70) ? FUNC_INSERT :
                    (pick < 85) ? FUNC_REMOVE : FUNC_DUMP;
            else
                f = (pick < 15) ? FUNC_APPEND : (pick < 30) ? FUNC_INSERT :
                    (pick < 80) ? FUNC_REMOVE : FUNC_DUMP;
            if (f == FUNC_INSERT && $urandom_range(0, 4) != 0)
                p = POS_W'($urandom_range(0, list_len));
            else
                p = POS_W'($urandom());
            send_request(f, draw_value(), p);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_value_extremes();
        test_full_store();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("** ordered_list_store: PASSED **");
        else
            $display("** ordered_list_store: FAILED **");
        $finish;
    end

endmodule
